// ===== sv/orlt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orlt_pkg
// Shared sizes and operation codes for the overwriting ring with lag tracking.
// ----------------------------------------------------------------------------
package orlt_pkg;

    // Ring depth must be a power of two (slot = counter modulo depth).
    localparam int ENTRIES      = 256;
    localparam int DATA_BITS    = 64;
    localparam int COUNT_BITS   = 32;

    localparam int SLOT_BITS    = $clog2(ENTRIES);
    localparam int PEND_BITS    = $clog2(ENTRIES + 1);

    // Fixed field widths on the ports
    localparam int FUNC_BITS    = 3;
    localparam int WORD_BITS    = 64;
    localparam int CNT_OUT_BITS = 32;

    typedef logic [FUNC_BITS-1:0]  func_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [PEND_BITS-1:0]  pend_t;
    typedef logic [DATA_BITS-1:0]  data_t;

    localparam func_t FN_PUBLISH      = 3'd0;
    localparam func_t FN_CONSUME      = 3'd1;
    localparam func_t FN_PEEK         = 3'd2;
    localparam func_t FN_RESYNC_CLEAR = 3'd3;
    localparam func_t FN_RESYNC       = 3'd4;

    localparam count_t RING_SIZE = COUNT_BITS'(ENTRIES);

endpackage

// ===== sv/overwriting_ring_with_lag_tracking.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_with_lag_tracking
// Single-writer ring that never blocks the writer on a full ring; one reader
// with overrun accounting. Entries live in a synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
// Results: publish, resync, undefined codes and empty reads register the result
//   at the transaction; consume/peek of a stored entry first passes through ST_READ.
// Throughput: one transaction per cycle while the output is not stalled, except
//   consume/peek hits, which hold the input in ST_READ while the RAM read returns.
// Reset: counters and drop total clear to zero; ring contents are not reset.
// ----------------------------------------------------------------------------
module overwriting_ring_with_lag_tracking
    import orlt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [FUNC_BITS-1:0]    func,
    input  logic [WORD_BITS-1:0]    wr_data,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    status,
    output logic [WORD_BITS-1:0]    rd_data,
    output logic [PEND_BITS-1:0]    pending,
    output logic                    has_data,
    output logic [CNT_OUT_BITS-1:0] drop_count,
    output logic [CNT_OUT_BITS-1:0] published_count
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic   state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    count_t wr_cnt_reg, wr_cnt_next;
    count_t rd_cnt_reg, rd_cnt_next;
    count_t lost_reg, lost_next;

    logic   status_reg, status_next;
    pend_t  pending_reg, pending_next;
    logic   has_data_reg, has_data_next;
    logic   rd_hit_reg, rd_hit_next;

    data_t  ring_mem [ENTRIES];
    data_t  rd_q_reg;

    logic   accept;
    logic   mem_wr;
    logic   mem_rd;
    slot_t  rd_slot;

    count_t diff;
    count_t diff_after;
    logic   empty;
    logic   overrun;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    assign diff    = wr_cnt_reg - rd_cnt_reg;
    assign empty   = (diff == '0);
    assign overrun = (diff > RING_SIZE);

    always_comb
    begin
        wr_cnt_next = wr_cnt_reg;
        rd_cnt_next = rd_cnt_reg;
        lost_next   = lost_reg;
        status_next = 1'b0;
        rd_hit_next = 1'b0;
        diff_after  = diff;
        mem_wr      = 1'b0;
        mem_rd      = 1'b0;
        // oldest surviving slot is wr - ENTRIES, same slot as wr
        rd_slot     = overrun ? wr_cnt_reg[SLOT_BITS-1:0] : rd_cnt_reg[SLOT_BITS-1:0];

        unique case (func)
            FN_PUBLISH:
            begin
                mem_wr      = 1'b1;
                wr_cnt_next = wr_cnt_reg + 1'b1;
                diff_after  = diff + 1'b1;
            end
            FN_CONSUME, FN_PEEK:
            begin
                if (empty)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    mem_rd      = 1'b1;
                    rd_hit_next = 1'b1;
                    if (func == FN_CONSUME)
                    begin
                        if (overrun)
                        begin
                            lost_next   = lost_reg + (diff - RING_SIZE);
                            rd_cnt_next = wr_cnt_reg - RING_SIZE + 1'b1;
                            diff_after  = RING_SIZE - 1'b1;
                        end
                        else
                        begin
                            rd_cnt_next = rd_cnt_reg + 1'b1;
                            diff_after  = diff - 1'b1;
                        end
                    end
                end
            end
            FN_RESYNC_CLEAR:
            begin
                rd_cnt_next = wr_cnt_reg;
                lost_next   = '0;
                diff_after  = '0;
            end
            FN_RESYNC:
            begin
                rd_cnt_next = wr_cnt_reg;
                diff_after  = '0;
            end
            default:
            begin
            end
        endcase

        has_data_next = (diff_after != '0);
        pending_next  = (diff_after > RING_SIZE) ? PEND_BITS'(ENTRIES)
                                                 : diff_after[PEND_BITS-1:0];
    end

    // Control sequencing and output register
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mem_rd)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                state_next     = ST_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            wr_cnt_reg    <= '0;
            rd_cnt_reg    <= '0;
            lost_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                wr_cnt_reg <= wr_cnt_next;
                rd_cnt_reg <= rd_cnt_next;
                lost_reg   <= lost_next;
            end
        end
    end

    // Result fields captured with the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            pending_reg  <= pending_next;
            has_data_reg <= has_data_next;
            rd_hit_reg   <= rd_hit_next;
        end
    end

    // Ring storage, one write or one read per transaction
    always_ff @(posedge clk)
    begin
        if (accept && mem_wr)
        begin
            ring_mem[wr_cnt_reg[SLOT_BITS-1:0]] <= wr_data[DATA_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && mem_rd)
        begin
            rd_q_reg <= ring_mem[rd_slot];
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign rd_data         = rd_hit_reg ? WORD_BITS'(rd_q_reg) : '0;
    assign pending         = pending_reg;
    assign has_data        = has_data_reg;
    assign drop_count      = CNT_OUT_BITS'(lost_reg);
    assign published_count = CNT_OUT_BITS'(wr_cnt_reg);

endmodule

// ===== test/overwriting_ring_with_lag_tracking_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_with_lag_tracking_tb
// Self-checking bench for the overwriting ring. A mirror of the ring (slots,
// write/read counters, drop total) predicts every result at input accept.
// Results are checked in order, field by field. Stimulus covers directed
// corner cases, ring overrun, a long output hold-off and random bursts, with
// random idling on both sides.
// ----------------------------------------------------------------------------
module overwriting_ring_with_lag_tracking_tb;
    import orlt_pkg::*;

    // func codes with no defined operation
    localparam func_t FN_SPARE_5 = 3'd5;
    localparam func_t FN_SPARE_6 = 3'd6;
    localparam func_t FN_SPARE_7 = 3'd7;

    localparam logic ST_OK    = 1'b0;
    localparam logic ST_EMPTY = 1'b1;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct packed {
        logic                    status;
        logic [WORD_BITS-1:0]    rd_data;
        logic [PEND_BITS-1:0]    pending;
        logic                    has_data;
        logic [CNT_OUT_BITS-1:0] drop_count;
        logic [CNT_OUT_BITS-1:0] published_count;
    } ring_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic [FUNC_BITS-1:0]    func;
    logic [WORD_BITS-1:0]    wr_data;
    logic                    out_valid;
    logic                    out_ready;
    logic                    status;
    logic [WORD_BITS-1:0]    rd_data;
    logic [PEND_BITS-1:0]    pending;
    logic                    has_data;
    logic [CNT_OUT_BITS-1:0] drop_count;
    logic [CNT_OUT_BITS-1:0] published_count;

    // mirror of the ring
    data_t  mirror_slots [ENTRIES];
    count_t mirror_wr;
    count_t mirror_rd;
    count_t mirror_lost;

    ring_result_t results_due[$];
    ring_result_t got;
    ring_result_t want;

    int unsigned items_in      = 0;
    int unsigned results_seen  = 0;
    int unsigned overrun_reads = 0;
    int unsigned empty_reads   = 0;
    int unsigned errors        = 0;
    int unsigned stall_cycles  = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_left     = 0;
    bit          steady        = 1'b0;

    overwriting_ring_with_lag_tracking i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .wr_data         (wr_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .rd_data         (rd_data),
        .pending         (pending),
        .has_data        (has_data),
        .drop_count      (drop_count),
        .published_count (published_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic ring_result_t predict_ring_result(func_t op, logic [WORD_BITS-1:0] word);
        ring_result_t r;
        count_t       lag;
        count_t       pos;
        r = '0;
        r.status = ST_OK;
        case (op)
            FN_PUBLISH:
            begin
                mirror_slots[mirror_wr[SLOT_BITS-1:0]] = word[DATA_BITS-1:0];
                mirror_wr = mirror_wr + 1'b1;
            end
            FN_CONSUME, FN_PEEK:
            begin
                if (mirror_rd == mirror_wr)
                begin
                    r.status = ST_EMPTY;
                    empty_reads++;
                end
                else
                begin
                    pos = mirror_rd;
                    lag = mirror_wr - mirror_rd;
                    // reader lapped: jump to the oldest surviving slot
                    if (lag > RING_SIZE)
                    begin
                        overrun_reads++;
                        pos = mirror_wr - RING_SIZE;
                        if (op == FN_CONSUME)
                            mirror_lost = mirror_lost + (lag - RING_SIZE);
                    end
                    r.rd_data = WORD_BITS'(mirror_slots[pos[SLOT_BITS-1:0]]);
                    if (op == FN_CONSUME)
                        mirror_rd = pos + 1'b1;
                end
            end
            FN_RESYNC_CLEAR:
            begin
                mirror_rd   = mirror_wr;
                mirror_lost = '0;
            end
            FN_RESYNC:
                mirror_rd = mirror_wr;
            default: ;
        endcase
        lag = mirror_wr - mirror_rd;
        r.pending         = (lag > RING_SIZE) ? PEND_BITS'(ENTRIES) : lag[PEND_BITS-1:0];
        r.has_data        = (mirror_rd != mirror_wr);
        r.drop_count      = CNT_OUT_BITS'(mirror_lost);
        r.published_count = CNT_OUT_BITS'(mirror_wr);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [WORD_BITS-1:0] exp_v,
                                   logic [WORD_BITS-1:0] act_v);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, exp_v, act_v);
    endtask

    // result checker and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            got = '{status, rd_data, pending, has_data, drop_count, published_count};
            if (results_due.size() == 0)
                report_mismatch("unexpected result", '0, got.rd_data);
            else
            begin
                want = results_due.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", WORD_BITS'(want.status),
                                    WORD_BITS'(got.status));
                if (got.rd_data !== want.rd_data)
                    report_mismatch("rd_data", want.rd_data, got.rd_data);
                if (got.pending !== want.pending)
                    report_mismatch("pending", WORD_BITS'(want.pending),
                                    WORD_BITS'(got.pending));
                if (got.has_data !== want.has_data)
                    report_mismatch("has_data", WORD_BITS'(want.has_data),
                                    WORD_BITS'(got.has_data));
                if (got.drop_count !== want.drop_count)
                    report_mismatch("drop_count", WORD_BITS'(want.drop_count),
                                    WORD_BITS'(got.drop_count));
                if (got.published_count !== want.published_count)
                    report_mismatch("published_count", WORD_BITS'(want.published_count),
                                    WORD_BITS'(got.published_count));
            end
        end
        if (rst_n !== 1'b1 || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
                $display("overwriting_ring_with_lag_tracking_tb: done, errors");
                $finish;
            end
        end
    end

    // result side: random stalls, optional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (steady)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 17);
    end

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return WORD_BITS'(1) << $urandom_range(WORD_BITS - 1);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic func_t pick_any_code();
        case ($urandom_range(7))
            0: return FN_PUBLISH;
            1: return FN_CONSUME;
            2: return FN_PEEK;
            3: return FN_RESYNC_CLEAR;
            4: return FN_RESYNC;
            5: return FN_SPARE_5;
            6: return FN_SPARE_6;
            default: return FN_SPARE_7;
        endcase
    endfunction

    // Offer one transaction, hold it until accepted, then predict its result.
    // Leaves in_valid high; random idling in the next call or wait_drained lowers it.
    task automatic send_op(func_t op, logic [WORD_BITS-1:0] word);
        while (!steady && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        wr_data  <= word;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        results_due.push_back(predict_ring_result(op, word));
        items_in++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_directed();
        send_op(FN_PEEK, '0);              // empty peek
        send_op(FN_CONSUME, '1);           // empty consume
        send_op(FN_PUBLISH, '0);
        send_op(FN_PUBLISH, '1);
        send_op(FN_PUBLISH, 64'h8000_0000_0000_0001);
        send_op(FN_PEEK, '0);
        send_op(FN_CONSUME, '0);
        send_op(FN_CONSUME, '0);
        send_op(FN_PEEK, '0);
        send_op(FN_CONSUME, '0);
        send_op(FN_CONSUME, '0);           // drained again
        send_op(FN_SPARE_5, '1);
        send_op(FN_SPARE_6, '1);
        send_op(FN_SPARE_7, '1);
        send_op(FN_PUBLISH, 64'h5555_AAAA_5555_AAAA);
        send_op(FN_PUBLISH, 64'hAAAA_5555_AAAA_5555);
        send_op(FN_RESYNC, '0);            // unread entries skipped, no drop
        send_op(FN_PEEK, '0);
        send_op(FN_PUBLISH, 64'h0123_4567_89AB_CDEF);
        send_op(FN_RESYNC_CLEAR, '0);
        send_op(FN_CONSUME, '0);
        wait_drained();
    endtask

    // Lap the reader so peek and consume see the oldest surviving slot.
    task automatic test_overrun();
        int unsigned n;
        for (n = 0; n < 300; n++)
            send_op(FN_PUBLISH, {n, $urandom});
        send_op(FN_PEEK, '0);
        send_op(FN_PEEK, '0);
        send_op(FN_CONSUME, '0);           // drops the excess
        send_op(FN_CONSUME, '0);
        repeat (3) send_op(FN_PUBLISH, pick_word());
        send_op(FN_RESYNC, '0);            // keeps drop count
        send_op(FN_CONSUME, '0);
        for (n = 0; n < 260; n++)
            send_op(FN_PUBLISH, pick_word());
        send_op(FN_CONSUME, '0);
        send_op(FN_RESYNC_CLEAR, '0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        int unsigned n;
        hold_req = HOLD_CYCLES;
        for (n = 0; n < 60; n++)
            send_op(($urandom_range(1) == 0) ? FN_PUBLISH : FN_CONSUME, pick_word());
        wait_drained();
    endtask

    task automatic test_random_traffic(int unsigned budget);
        int unsigned start;
        int unsigned burst;
        int unsigned mode;
        start = items_in;
        while (items_in - start < budget)
        begin
            steady = (items_in - start >= 400) && (items_in - start < 600);
            mode   = $urandom_range(99);
            if (mode < 65)
            begin
                burst = $urandom_range(1, 24);
                repeat (burst) send_op(FN_PUBLISH, pick_word());
                burst = $urandom_range(1, burst + 3);
                repeat (burst)
                    send_op(($urandom_range(3) == 0) ? FN_PEEK : FN_CONSUME, pick_word());
            end
            else if (mode < 67)
            begin
                burst = $urandom_range(250, 270);
                repeat (burst) send_op(FN_PUBLISH, pick_word());
                burst = $urandom_range(1, 4);
                repeat (burst)
                    send_op(($urandom_range(2) == 0) ? FN_PEEK : FN_CONSUME, pick_word());
            end
            else if (mode < 75)
                send_op(($urandom_range(1) == 0) ? FN_RESYNC : FN_RESYNC_CLEAR, pick_word());
            else
            begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_op(pick_any_code(), pick_word());
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        func      = FN_PUBLISH;
        wr_data   = '0;
        out_ready = 1'b0;
        mirror_wr   = '0;
        mirror_rd   = '0;
        mirror_lost = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_overrun();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        wait_drained();
        repeat (20) @(posedge clk);
        if (results_due.size() != 0)
            report_mismatch("missing results", WORD_BITS'(results_due.size()), '0);
        $display("covered %0d transactions, %0d results checked", items_in, results_seen);
        $display("reads: %0d across overrun, %0d on empty ring", overrun_reads, empty_reads);
        if (errors == 0)
            $display("overwriting_ring_with_lag_tracking_tb: done, clean");
        else
            $display("overwriting_ring_with_lag_tracking_tb: done, errors");
        $finish;
    end

endmodule
